@@ rtl/ssbs_pkg.sv @@
// Shared constants and control types for the sorted set search unit.
package ssbs_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int POS_W        = 7;

	localparam logic [1:0] OP_FIND  = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic cmp;
		logic decide;
		logic sh_rd;
		logic sh_wr;
		logic ins_wr;
		logic load_out;
	} ssbs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_clear;
		logic search_end;
		logic ins_ok;
		logic at_pos;
	} ssbs_stat_t;

endpackage

@@ rtl/ssbs_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ssbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ssbs_ctrl.sv @@
// Sequencer for search, insert shift and result hand-off.
module ssbs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ssbs_pkg::ssbs_stat_t stat,
	output ssbs_pkg::ssbs_cmd_t  cmd
);
	import ssbs_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_CMP    = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_SH_CHK = 3'd4;
	localparam logic [2:0] S_SH_WR  = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_n   = S_SEARCH;
				end
			end
			S_SEARCH: begin
				// probe read of mid is issued here; data is compared next cycle
				if (stat.is_clear || stat.search_end) begin
					state_n = S_DECIDE;
				end else begin
					state_n = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_n = S_SEARCH;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_n    = stat.ins_ok ? S_SH_CHK : S_FIN;
			end
			S_SH_CHK: begin
				if (stat.at_pos) begin
					cmd.ins_wr = 1'b1;
					state_n    = S_FIN;
				end else begin
					cmd.sh_rd = 1'b1;
					state_n   = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_n   = S_SH_CHK;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/ssbs_dp.sv @@
// Key table, bisection bounds, shift index and result registers.
module ssbs_dp #(
	parameter int CAPACITY = ssbs_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = ssbs_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssbs_pkg::ssbs_cmd_t         cmd,
	output ssbs_pkg::ssbs_stat_t        stat,
	input  logic                        cfg_we,
	input  logic                        cfg_order,
	input  logic [1:0]                  operation,
	input  logic [KEY_BITS-1:0]         key,
	input  logic                        force_req,
	output logic                        found,
	output logic [ssbs_pkg::POS_W-1:0]  position,
	output logic [1:0]                  status,
	output logic [ssbs_pkg::POS_W-1:0]  count
);
	import ssbs_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [KEY_BITS-1:0] SIGN_BIT = KEY_BITS'(1) << (KEY_BITS - 1);

	logic                order_q;
	logic [CNT_W-1:0]    count_q;
	logic [KEY_BITS-1:0] key_q;
	logic [1:0]          op_q;
	logic                force_q;
	logic [CNT_W-1:0]    lo_q;
	logic [CNT_W-1:0]    hi_q;
	logic [CNT_W-1:0]    idx_q;
	logic                found_q;
	logic [1:0]          status_q;

	logic [CNT_W:0]      sum;
	logic [CNT_W-1:0]    mid;
	logic [CNT_W-1:0]    idx_m1;
	logic [KEY_BITS-1:0] flip;
	logic [KEY_BITS-1:0] tgt;
	logic [KEY_BITS-1:0] probe;
	logic [KEY_BITS-1:0] rdata;
	logic [AW-1:0]       raddr;
	logic                is_add;
	logic                is_clear;
	logic                dup;
	logic                full;
	logic [1:0]          status_n;

	always_comb begin
		sum      = {1'b0, lo_q} + {1'b0, hi_q};
		mid      = sum[CNT_W:1];
		idx_m1   = idx_q - 1'b1;
		// flipping the sign bit maps two's complement order onto unsigned order
		flip     = order_q ? SIGN_BIT : '0;
		tgt      = key_q ^ flip;
		probe    = rdata ^ flip;
		is_add   = (op_q == OP_ADD);
		is_clear = (op_q == OP_CLEAR);
		dup      = found_q && !force_q;
		full     = (count_q >= CNT_W'(CAPACITY));
		raddr    = cmd.sh_rd ? idx_m1[AW-1:0] : mid[AW-1:0];
		priority if (is_clear) begin
			status_n = ST_DONE;
		end else if (is_add) begin
			status_n = dup ? ST_DUPLICATE : (full ? ST_FULL : ST_DONE);
		end else begin
			status_n = found_q ? ST_DONE : ST_NOT_FOUND;
		end
		stat.is_clear   = is_clear;
		stat.search_end = found_q || (lo_q >= hi_q);
		stat.ins_ok     = is_add && !dup && !full;
		stat.at_pos     = (idx_q == lo_q);
	end

	ssbs_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.sh_wr || cmd.ins_wr),
		.waddr(idx_q[AW-1:0]),
		.wdata(cmd.ins_wr ? key_q : rdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_order;
			end
			if (cmd.decide && is_clear) begin
				count_q <= '0;
			end else if (cmd.ins_wr) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= key;
			op_q    <= operation;
			force_q <= force_req;
			lo_q    <= '0;
			hi_q    <= count_q;
			found_q <= 1'b0;
		end
		if (cmd.cmp) begin
			priority if (tgt < probe) begin
				hi_q <= mid;
			end else if (tgt > probe) begin
				lo_q <= mid + 1'b1;
			end else begin
				found_q <= 1'b1;
				lo_q    <= mid;
			end
		end
		if (cmd.decide) begin
			status_q <= status_n;
			idx_q    <= count_q;
			if (is_clear) begin
				lo_q    <= '0;
				found_q <= 1'b0;
			end
		end
		if (cmd.sh_wr) begin
			idx_q <= idx_m1;
		end
		if (cmd.load_out) begin
			found    <= found_q;
			position <= POS_W'(lo_q);
			status   <= status_q;
			count    <= POS_W'(count_q);
		end
	end

endmodule

@@ rtl/sorted_set_binary_search_unit.sv @@
// Sorted key set with bisection search, insert and clear: top level.
// One request at a time. The key table sits in a RAM with one registered read
// port, so each bisection probe is a read of the middle entry followed by a
// compare. An add that inserts also moves every entry above the insert point up
// by one, reading and then writing each moved entry before the new key is
// written. A new request is taken once the previous one has moved its result
// into the output register, even while that result is still stalled. The user
// must write configuration (signed or unsigned compare) on the cfg channel only
// while no request is open; the block itself does not enforce this.
module sorted_set_binary_search_unit #(
	parameter int CAPACITY = ssbs_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = ssbs_pkg::KEY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       key_order_signed,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [KEY_BITS-1:0]        key,
	input  logic                       force_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [ssbs_pkg::POS_W-1:0] position,
	output logic [1:0]                 status,
	output logic [ssbs_pkg::POS_W-1:0] count
);
	import ssbs_pkg::*;

	ssbs_cmd_t  cmd;
	ssbs_stat_t stat;

	assign cfg_ready = 1'b1;

	ssbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssbs_dp #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_order(key_order_signed),
		.operation(operation),
		.key      (key),
		.force_req(force_req),
		.found    (found),
		.position (position),
		.status   (status),
		.count    (count)
	);

endmodule

@@ rtl/ssbs_checker.sv @@
// Port-level checks for the sorted set search unit, bound to the top level.
module ssbs_checker #(
	parameter int CAPACITY = ssbs_pkg::CAPACITY_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       found,
	input logic [1:0]                 status,
	input logic [ssbs_pkg::POS_W-1:0] count
);
	import ssbs_pkg::*;

	// an accepted request keeps the block busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted but block not busy next cycle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DUPLICATE) |-> found)
		else $error("duplicate refusal without a match");

	a_miss_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND) |-> !found)
		else $error("not-found status with found set");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAPACITY > 127) || (count <= POS_W'(CAPACITY)))
		else $error("entry count above capacity");

endmodule

bind sorted_set_binary_search_unit ssbs_checker #(
	.CAPACITY(CAPACITY)
) u_ssbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.found    (found),
	.status   (status),
	.count    (count)
);

@@ tb/sv/tb_sorted_set_binary_search_unit.sv @@
// Testbench for the sorted set search unit: directed and random find/add/clear against a predictor.
module tb_sorted_set_binary_search_unit;
	import ssbs_pkg::*;

	localparam int          CAPACITY       = CAPACITY_DEF;
	localparam logic [1:0]  OP_UNUSED      = 2'd3;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [1:0]       status;
		logic [POS_W-1:0] count;
	} search_result_t;

	logic             clk              = 1'b0;
	logic             arst_n           = 1'b0;
	logic             cfg_valid        = 1'b0;
	logic             cfg_ready;
	logic             key_order_signed = 1'b0;
	logic             in_valid         = 1'b0;
	logic             in_stall;
	logic [1:0]       operation        = OP_FIND;
	logic [31:0]      key              = '0;
	logic             force_req        = 1'b0;
	logic             out_valid;
	logic             out_stall        = 1'b0;
	logic             found;
	logic [POS_W-1:0] position;
	logic [1:0]       status;
	logic [POS_W-1:0] count;

	// predictor state
	logic [31:0]    table_keys [CAPACITY];
	int             table_count  = 0;
	logic           order_signed = 1'b0;
	search_result_t pending_results [$];

	int             failures     = 0;
	bit             no_idle      = 1'b0;
	int unsigned    quiet_cycles = 0;
	search_result_t oldest;

	sorted_set_binary_search_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.key_order_signed (key_order_signed),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.key              (key),
		.force_req        (force_req),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.found            (found),
		.position         (position),
		.status           (status),
		.count            (count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// flipping the sign bit turns two's complement order into unsigned order
	function automatic logic [31:0] order_of(input logic [31:0] k);
		return order_signed ? (k ^ 32'h8000_0000) : k;
	endfunction

	function automatic int bisect_table(input logic [31:0] k, output logic hit);
		int          lo;
		int          hi;
		int          mid;
		logic [31:0] target;
		logic [31:0] probe;
		lo     = 0;
		hi     = table_count;
		hit    = 1'b0;
		target = order_of(k);
		while (lo < hi) begin
			mid   = (lo + hi) / 2;
			probe = order_of(table_keys[mid]);
			if (target < probe) begin
				hi = mid;
			end else if (target > probe) begin
				lo = mid + 1;
			end else begin
				hit = 1'b1;
				return mid;
			end
		end
		return lo;
	endfunction

	function automatic search_result_t apply_request(input logic [1:0] op, input logic [31:0] k,
			input logic frc);
		search_result_t r;
		logic           hit;
		int             pos;
		hit      = 1'b0;
		pos      = 0;
		r.status = ST_DONE;
		if (op == OP_CLEAR) begin
			table_count = 0;
		end else if (op == OP_ADD) begin
			pos = bisect_table(k, hit);
			if (hit && !frc) begin
				r.status = ST_DUPLICATE;
			end else if (table_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				for (int i = table_count; i > pos; i--)
					table_keys[i] = table_keys[i-1];
				table_keys[pos] = k;
				table_count++;
			end
		end else begin
			pos      = bisect_table(k, hit);
			r.status = hit ? ST_DONE : ST_NOT_FOUND;
		end
		r.found    = hit;
		r.position = POS_W'(pos);
		r.count    = POS_W'(table_count);
		return r;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [31:0] k, input logic frc);
		while (!no_idle && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		key       <= k;
		force_req <= frc;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		pending_results.push_back(apply_request(op, k, frc));
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic write_key_order(input logic signed_mode);
		wait_for_results();
		repeat (2) @(posedge clk);
		cfg_valid        <= 1'b1;
		key_order_signed <= signed_mode;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		order_signed = signed_mode;
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// many keys are stored keys or close to them, so hits and duplicates are common
	function automatic logic [31:0] pick_key();
		int          r;
		logic [31:0] k;
		r = $urandom_range(99);
		if (r < 35 && table_count > 0) begin
			k = table_keys[$urandom_range(table_count - 1)];
			case ($urandom_range(3))
				0: k = k + 1;
				1: k = k - 1;
				default: ;
			endcase
		end else if (r < 55) begin
			k = 32'($urandom_range(15));
			if ($urandom_range(1))
				k = ~k;
		end else if (r < 65) begin
			case ($urandom_range(3))
				0: k = 32'h0000_0000;
				1: k = 32'hFFFF_FFFF;
				2: k = 32'h8000_0000;
				default: k = 32'h7FFF_FFFF;
			endcase
		end else begin
			k = $urandom;
		end
		return k;
	endfunction

	task automatic test_directed_unsigned();
		send_request(OP_FIND,   32'h0000_0000, 1'b0);
		send_request(OP_ADD,    32'h8000_0000, 1'b0);
		send_request(OP_ADD,    32'h0000_0000, 1'b0);
		send_request(OP_ADD,    32'hFFFF_FFFF, 1'b0);
		send_request(OP_ADD,    32'h7FFF_FFFF, 1'b0);
		send_request(OP_ADD,    32'h7FFF_FFFF, 1'b0);
		send_request(OP_ADD,    32'h7FFF_FFFF, 1'b1);
		send_request(OP_FIND,   32'hFFFF_FFFF, 1'b1);
		send_request(OP_FIND,   32'h0000_0000, 1'b0);
		send_request(OP_FIND,   32'h0001_2345, 1'b0);
		send_request(OP_UNUSED, 32'h8000_0000, 1'b1);
		send_request(OP_CLEAR,  32'hFFFF_FFFF, 1'b1);
		send_request(OP_FIND,   32'h0000_0000, 1'b0);
	endtask

	task automatic test_directed_signed();
		send_request(OP_ADD,   32'h8000_0000, 1'b0);
		send_request(OP_ADD,   32'h7FFF_FFFF, 1'b0);
		send_request(OP_ADD,   32'hFFFF_FFFF, 1'b0);
		send_request(OP_ADD,   32'h0000_0000, 1'b0);
		send_request(OP_FIND,  32'h8000_0000, 1'b0);
		send_request(OP_FIND,  32'hFFFF_FFFF, 1'b0);
		send_request(OP_ADD,   32'h8000_0000, 1'b1);
		send_request(OP_CLEAR, 32'h0000_0000, 1'b0);
	endtask

	// fill to capacity, then duplicate-refused must win over table-full
	task automatic test_full_table();
		logic [31:0] k;
		send_request(OP_CLEAR, $urandom, 1'($urandom_range(1)));
		while (table_count < CAPACITY)
			send_request(OP_ADD, pick_key(), 1'b1);
		k = table_keys[$urandom_range(CAPACITY - 1)];
		send_request(OP_ADD, k, 1'b0);
		send_request(OP_ADD, k, 1'b1);
		send_request(OP_ADD, $urandom, 1'b1);
		send_request(OP_ADD, 32'hFFFF_FFFF, 1'b0);
		send_request(OP_ADD, 32'h8000_0000, 1'b0);
		send_request(OP_FIND, k, 1'b0);
		send_request(OP_UNUSED, table_keys[0], 1'b1);
		send_request(OP_FIND, table_keys[CAPACITY - 1], 1'b0);
		send_request(OP_CLEAR, 32'h0, 1'b0);
	endtask

	task automatic test_random_requests(input int n_items, input bit steady);
		int         r;
		logic [1:0] op;
		no_idle = steady;
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(999);
			if (r < 15)
				op = OP_CLEAR;
			else if (r < 30)
				op = OP_UNUSED;
			else if (r < 580)
				op = OP_ADD;
			else
				op = OP_FIND;
			send_request(op, pick_key(), $urandom_range(99) < 30);
			if (n % 150 == 149)
				wait_for_results();
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk)
		out_stall <= !no_idle && ($urandom_range(99) < 14);

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				oldest = pending_results.pop_front();
				if (found !== oldest.found) begin
					$error("found: expected %0d, actual %0d", oldest.found, found);
					failures++;
				end
				if (position !== oldest.position) begin
					$error("position: expected %0d, actual %0d", oldest.position, position);
					failures++;
				end
				if (status !== oldest.status) begin
					$error("status: expected %0d, actual %0d", oldest.status, status);
					failures++;
				end
				if (count !== oldest.count) begin
					$error("count: expected %0d, actual %0d", oldest.count, count);
					failures++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_unsigned();
		write_key_order(1'b1);
		test_directed_signed();
		test_full_table();
		write_key_order(1'b0);
		test_full_table();
		test_random_requests(450, 1'b0);
		write_key_order(1'b1);
		test_random_requests(450, 1'b1);
		write_key_order(1'b0);
		test_random_requests(450, 1'b0);
		write_key_order(1'b1);
		test_random_requests(450, 1'b0);
		wait_for_results();
		repeat (200) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
